### hw/rtl/lfsa_pkg.sv
// ----------------------------------------------------------------------------
// lfsa_pkg: shared definitions for the lowest-free-slot ID allocator
// Field widths, status codes, controller states and the cell command bundle.
// ----------------------------------------------------------------------------
package lfsa_pkg;

   // Default configuration
   localparam int DEF_NUM_SLOTS   = 64;
   localparam int DEF_HANDLE_BITS = 32;

   // Fixed port field widths
   localparam int HANDLE_W = 32;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // Request modes
   localparam logic MODE_CREATE = 1'b0;
   localparam logic MODE_DELETE = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_INVALID   = 2'd3;

   // Controller states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_REJECT = 3'b100
   } state_type;

   // Broadcast from the controller to every cell
   typedef struct packed {
      logic adv;   // chain may move and cells may write this cycle
      logic del;   // current transaction is a delete
   } cell_cmd_type;

endpackage

### hw/rtl/lfsa_cell.sv
// ----------------------------------------------------------------------------
// lfsa_cell: one slot of the allocator chain
// Holds one handle. A search token enters from the left neighbor; the cell
// claims it on a match, otherwise hands it to the right neighbor.
// ----------------------------------------------------------------------------
module lfsa_cell #(
   parameter int HANDLE_BITS = lfsa_pkg::DEF_HANDLE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lfsa_pkg::cell_cmd_type cmd,
   input  logic [HANDLE_BITS-1:0] key,
   input  logic                   pass_in,
   output logic                   pass_out,
   output logic                   hit
);

   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic                   active_ff, active_in;
   logic                   match;

   // Create looks for an empty slot, delete for the same handle
   assign match    = cmd.del ? (handle_ff == key) : (handle_ff == '0);
   assign hit      = active_ff && match;
   assign pass_out = active_ff && !match;

   always_comb begin
      handle_in = handle_ff;
      active_in = active_ff;
      if (cmd.adv) begin
         active_in = pass_in;
         if (hit) begin
            handle_in = cmd.del ? '0 : key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         handle_ff <= '0;
         active_ff <= 1'b0;
      end else begin
         handle_ff <= handle_in;
         active_ff <= active_in;
      end
   end

endmodule

### hw/rtl/lowest_free_slot_id_allocator.sv
// ----------------------------------------------------------------------------
// lowest_free_slot_id_allocator: lowest-free-slot object numbering
// Create stores a handle in the lowest empty slot and returns its index;
// delete clears the lowest slot holding the handle. Slots live in a chain
// of cells that a search token walks one cell per cycle.
// ----------------------------------------------------------------------------
//
//   channel | direction | fields                                  | handshake
//   --------+-----------+-----------------------------------------+----------
//   req     | in        | mode, handle                            | valid/ready
//   rsp     | out       | slot_index, status, live_count          | valid/ready
//
// - A transaction that lands in slot k returns its response once the token has walked
//   the cell chain up to cell k; a miss (full table, unknown handle) answers once the
//   token has left the last cell of the chain.
// - A zero handle is rejected through the reject state without touching the slots.
// - One transaction is in flight at a time; req_ready is high while idle and
//   the output register is empty or being taken in the same cycle.
// - A stalled response holds off the next request, so a scan never stalls.
// - Reset clears every slot, the live count, the controller state and the response valid flag.
//
module lowest_free_slot_id_allocator #(
   parameter int NUM_SLOTS   = lfsa_pkg::DEF_NUM_SLOTS,
   parameter int HANDLE_BITS = lfsa_pkg::DEF_HANDLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [lfsa_pkg::HANDLE_W-1:0] req_handle,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lfsa_pkg::INDEX_W-1:0]  rsp_slot_index,
   output logic [lfsa_pkg::STATUS_W-1:0] rsp_status,
   output logic [lfsa_pkg::COUNT_W-1:0]  rsp_live_count
);

   localparam int IDX_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
   localparam int IDX_EXT = IDX_W + lfsa_pkg::INDEX_W;
   localparam int CNT_EXT = CNT_W + lfsa_pkg::COUNT_W;
   localparam int HND_EXT = HANDLE_BITS + lfsa_pkg::HANDLE_W;

   // Controller state
   lfsa_pkg::state_type             state_ff, state_in;
   logic                            mode_ff, mode_in;
   logic [HANDLE_BITS-1:0]          key_ff, key_in;
   logic [IDX_W-1:0]                pos_ff, pos_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;

   // Output register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [lfsa_pkg::INDEX_W-1:0]    index_ff, index_in;
   logic [lfsa_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [lfsa_pkg::COUNT_W-1:0]    live_ff, live_in;

   // Chain wiring
   lfsa_pkg::cell_cmd_type          cmd;
   logic [NUM_SLOTS:0]              pass;
   logic [NUM_SLOTS-1:0]            hit_vec;
   logic                            hit_any;
   logic                            miss;
   logic                            adv;
   logic                            launch;
   logic                            accept;

   logic [HND_EXT-1:0]              handle_ext;
   logic [HANDLE_BITS-1:0]          req_key;
   logic [IDX_EXT-1:0]              pos_ext;
   logic [CNT_EXT-1:0]              cnt_ext;

   // Keep only the handle bits the table stores
   assign handle_ext = HND_EXT'(req_handle);
   assign req_key    = handle_ext[HANDLE_BITS-1:0];

   // Hold off a new transaction while a finished response is blocked, so the
   // token always enters the chain on the accepting edge
   assign req_ready = (state_ff == lfsa_pkg::ST_IDLE) && adv;
   assign accept    = req_valid && req_ready;
   assign launch    = accept && (req_key != '0);

   // Advance unless a finished response is blocked; idle chain is empty anyway
   assign adv = !(rsp_valid_ff && !rsp_ready);

   assign cmd.adv = adv;
   assign cmd.del = mode_ff;

   assign pass[0] = launch;

   genvar g;
   generate
      for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
         lfsa_cell #(
            .HANDLE_BITS(HANDLE_BITS)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .cmd     (cmd),
            .key     (key_ff),
            .pass_in (pass[g]),
            .pass_out(pass[g+1]),
            .hit     (hit_vec[g])
         );
      end
   endgenerate

   assign hit_any = |hit_vec;
   assign miss    = pass[NUM_SLOTS];

   assign pos_ext = IDX_EXT'(pos_ff);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      index_in     = index_ff;
      status_in    = status_ff;
      cnt_ext      = CNT_EXT'(cnt_ff);
      live_in      = cnt_ext[lfsa_pkg::COUNT_W-1:0];

      // Drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         lfsa_pkg::ST_IDLE: begin
            if (accept) begin
               mode_in  = req_mode;
               key_in   = req_key;
               pos_in   = '0;
               state_in = launch ? lfsa_pkg::ST_SCAN : lfsa_pkg::ST_REJECT;
            end
         end
         lfsa_pkg::ST_SCAN: begin
            if (adv) begin
               pos_in = pos_ff + IDX_W'(1);
               if (hit_any) begin
                  // Claimed slot: update the count with saturation
                  if (mode_ff == lfsa_pkg::MODE_DELETE) begin
                     if (cnt_ff != '0) begin
                        cnt_in = cnt_ff - CNT_W'(1);
                     end
                  end else begin
                     if (cnt_ff < CNT_W'(NUM_SLOTS)) begin
                        cnt_in = cnt_ff + CNT_W'(1);
                     end
                  end
                  cnt_ext      = CNT_EXT'(cnt_in);
                  live_in      = cnt_ext[lfsa_pkg::COUNT_W-1:0];
                  index_in     = pos_ext[lfsa_pkg::INDEX_W-1:0];
                  status_in    = lfsa_pkg::STATUS_OK;
                  rsp_valid_in = 1'b1;
                  state_in     = lfsa_pkg::ST_IDLE;
               end else if (miss) begin
                  index_in     = '0;
                  status_in    = (mode_ff == lfsa_pkg::MODE_DELETE) ?
                                 lfsa_pkg::STATUS_NOT_FOUND : lfsa_pkg::STATUS_FULL;
                  rsp_valid_in = 1'b1;
                  state_in     = lfsa_pkg::ST_IDLE;
               end
            end
         end
         lfsa_pkg::ST_REJECT: begin
            // Zero handle: answer without touching the slots
            if (adv) begin
               index_in     = '0;
               status_in    = lfsa_pkg::STATUS_INVALID;
               rsp_valid_in = 1'b1;
               state_in     = lfsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lfsa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfsa_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      key_ff    <= key_in;
      pos_ff    <= pos_in;
      index_ff  <= index_in;
      status_ff <= status_in;
      live_ff   <= live_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_index = index_ff;
   assign rsp_status     = status_ff;
   assign rsp_live_count = live_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // Only one token walks the chain, so at most one cell claims it
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one cell claimed the search token");

   // Cells only claim while a scan is running
   a_hit_in_scan: assert property (@(posedge clock) disable iff (reset)
      hit_any |-> (state_ff == lfsa_pkg::ST_SCAN))
      else $error("cell hit outside of a scan");

   // A claimed slot ends the scan
   a_hit_ends_scan: assert property (@(posedge clock) disable iff (reset)
      (hit_any && adv) |=> (state_ff == lfsa_pkg::ST_IDLE) && rsp_valid_ff)
      else $error("scan did not finish after a hit");

   // The live count never exceeds the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(NUM_SLOTS))
      else $error("live count above table size");

   // A new response only comes out of a scan or a reject
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) != lfsa_pkg::ST_IDLE))
      else $error("response raised from idle");

endmodule
